### rtl/lse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants for the log-sum-exp reducer
// Transfer payload structs and the fixed-point constants of the datapath.
// ----------------------------------------------------------------------------
package lse_pkg;

   localparam int VALUE_W = 24;

   typedef struct packed {
      logic signed [VALUE_W-1:0] log_value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] log_sum;
      logic                      saturated;
   } rsp_type;

   localparam logic signed [VALUE_W-1:0] MOST_NEG = 24'sh800000;
   localparam logic signed [VALUE_W-1:0] MOST_POS = 24'sh7FFFFF;

   localparam logic [31:0] ONE31     = 32'h8000_0000;
   localparam logic [31:0] LN2_Q31   = 32'd1488522236;
   localparam logic [23:0] EXP_LIMIT = 24'd786432;   // 12.0 in Q.16
   localparam logic [31:0] MIN_SUM   = 32'd65536;    // 1.0 in Q.16

   localparam int TAYLOR_TERMS = 24;
   localparam int SQUARINGS    = 4;
   localparam int LOG_BITS     = 30;
   localparam int DIV_CYCLES   = 8;                  // 4 quotient bits a cycle

endpackage

### rtl/log_sum_exp_reducer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_sum_exp_reducer_unit: log-sum-exp over a vector of Q8.16 values
// Elements load into a buffer while a running max is kept; after the last
// element one shared 32x32 multiplier computes every exp term and the log.
// ----------------------------------------------------------------------------
// Load: one element transfers each cycle; req_stall stays low while collecting.
// After the last element, each stored element is read, run through 24 Taylor
// multiply/divide rounds, clamped, squared 4 times and added; one past the 12.0
// cutoff goes straight to the add. Then come normalize, 30 log squarings,
// scaling and output; all share one multiplier. A stalled result holds input.
// Reset clears count, max and flags at once; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module log_sum_exp_reducer_unit #(
   parameter int MAX_ITEMS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lse_pkg::rsp_type rsp_data
);
   import lse_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W  = $clog2(MAX_ITEMS) + 17;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_X, S_TMUL, S_TDIV, S_CLAMP, S_SQ, S_ACC,
      S_NINIT, S_NORM, S_LOG, S_LN1, S_LN2, S_OUT
   } state_type;

   state_type state_ff;

   // element buffer, read data registered
   logic [VALUE_W-1:0] mem [MAX_ITEMS];
   logic [VALUE_W-1:0] rd_ff;

   logic [CNT_W-1:0]          cnt_ff, idx_ff;
   logic signed [VALUE_W-1:0] max_ff;
   logic                      ovf_ff;
   logic [SUM_W-1:0]          sum_ff;

   logic [31:0]        y_ff, term_ff, div_ff, e_ff, m_ff;
   logic signed [33:0] acc_ff;
   logic [5:0]         rem_ff;
   logic [4:0]         n_ff;
   logic [2:0]         dcnt_ff;
   logic [1:0]         sq_ff;
   logic [4:0]         lcnt_ff, p_ff;
   logic [29:0]        frac_ff;
   logic [35:0]        tot_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic accept;
   logic out_fire;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_fire  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_TMUL: begin mul_a = term_ff;               mul_b = y_ff;    end
         S_SQ:   begin mul_a = e_ff;                  mul_b = e_ff;    end
         S_LOG:  begin mul_a = m_ff;                  mul_b = m_ff;    end
         S_LN1:  begin mul_a = {2'b00, frac_ff};      mul_b = LN2_Q31; end
         S_LN2:  begin mul_a = {27'd0, p_ff - 5'd16}; mul_b = LN2_Q31; end
         default: ;
      endcase
   end
   assign product = {32'd0, mul_a} * {32'd0, mul_b};

   // four restoring division steps by n
   logic [5:0]  div_r;
   logic [31:0] div_d;
   always_comb begin
      div_r = rem_ff;
      div_d = div_ff;
      for (int k = 0; k < 4; k++) begin
         div_r = {div_r[4:0], div_d[31]};
         div_d = {div_d[30:0], 1'b0};
         if (div_r >= {1'b0, n_ff}) begin
            div_r  = div_r - {1'b0, n_ff};
            div_d[0] = 1'b1;
         end
      end
   end

   // exp argument and misc datapath
   logic [VALUE_W-1:0] x_diff;
   logic [31:0]        sq_sum, mm, m_next;
   logic [32:0]        e_round;
   logic [63:0]        fp_sum;
   logic [36:0]        tot_round;
   logic signed [25:0] res_full;
   logic [SUM_W-1:0]   sum_next;
   logic signed [33:0] term_ext;

   assign x_diff    = max_ff - rd_ff;
   assign sq_sum    = 32'((product + 64'd1073741824) >> 31);
   assign mm        = product[61:30];
   assign m_next    = mm[31] ? {1'b0, mm[31:1]} : mm;
   assign e_round   = {1'b0, e_ff} + 33'd16384;
   assign sum_next  = sum_ff + SUM_W'(e_round[32:15]);
   assign fp_sum    = product + 64'd536870912;
   assign tot_round = {1'b0, tot_ff} + 37'd16384;
   assign res_full  = 26'(signed'(max_ff)) + signed'({4'd0, tot_round[36:15]});
   assign term_ext  = signed'({2'b00, div_d});

   // buffer write and registered read
   always_ff @(posedge clock) begin
      if (accept && cnt_ff < MAX_CNT) begin
         mem[cnt_ff[ADDR_W-1:0]] <= req_data.log_value;
      end
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         max_ff       <= MOST_NEG;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise the result when it is formed, drop it once its transfer completes
         if (out_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (cnt_ff < MAX_CNT) begin
                     if (req_data.log_value > max_ff) max_ff <= req_data.log_value;
                     cnt_ff <= cnt_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_data.is_last) begin
                     idx_ff   <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_X;
            S_X: begin
               if (x_diff >= EXP_LIMIT) begin
                  e_ff     <= '0;
                  state_ff <= S_ACC;
               end else begin
                  y_ff     <= {x_diff[20:0], 11'd0};
                  term_ff  <= ONE31;
                  acc_ff   <= 34'sd2147483648;
                  n_ff     <= 5'd1;
                  state_ff <= S_TMUL;
               end
            end
            S_TMUL: begin
               div_ff   <= product[62:31];
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_TDIV;
            end
            S_TDIV: begin
               div_ff  <= div_d;
               rem_ff  <= div_r;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 3'(DIV_CYCLES - 1)) begin
                  term_ff <= div_d;
                  acc_ff  <= n_ff[0] ? acc_ff - term_ext : acc_ff + term_ext;
                  if (n_ff == 5'(TAYLOR_TERMS)) begin
                     state_ff <= S_CLAMP;
                  end else begin
                     n_ff     <= n_ff + 1'b1;
                     state_ff <= S_TMUL;
                  end
               end
            end
            S_CLAMP: begin
               priority if (acc_ff < 0) e_ff <= '0;
               else if (acc_ff > 34'sd2147483648) e_ff <= ONE31;
               else e_ff <= acc_ff[31:0];
               sq_ff    <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               e_ff  <= sq_sum;
               sq_ff <= sq_ff + 1'b1;
               if (sq_ff == 2'(SQUARINGS - 1)) state_ff <= S_ACC;
            end
            S_ACC: begin
               sum_ff <= sum_next;
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == cnt_ff) state_ff <= S_NINIT;
               else state_ff <= S_RD;
            end
            S_NINIT: begin
               m_ff     <= (32'(sum_ff) < MIN_SUM) ? MIN_SUM : 32'(sum_ff);
               p_ff     <= 5'd30;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (m_ff[30]) begin
                  lcnt_ff  <= '0;
                  frac_ff  <= '0;
                  state_ff <= S_LOG;
               end else begin
                  m_ff <= {m_ff[30:0], 1'b0};
                  p_ff <= p_ff - 1'b1;
               end
            end
            S_LOG: begin
               m_ff    <= m_next;
               frac_ff <= {frac_ff[28:0], mm[31]};
               lcnt_ff <= lcnt_ff + 1'b1;
               if (lcnt_ff == 5'(LOG_BITS - 1)) state_ff <= S_LN1;
            end
            S_LN1: begin
               tot_ff   <= {3'd0, fp_sum[62:30]};
               state_ff <= S_LN2;
            end
            S_LN2: begin
               tot_ff   <= product[35:0] + tot_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (out_fire) begin
                  if (res_full > 26'sd8388607) begin
                     rsp_ff.log_sum   <= MOST_POS;
                     rsp_ff.saturated <= 1'b1;
                  end else begin
                     rsp_ff.log_sum   <= res_full[23:0];
                     rsp_ff.saturated <= ovf_ff;
                  end
                  cnt_ff   <= '0;
                  max_ff   <= MOST_NEG;
                  ovf_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // a vector's end closes the input until its result is formed
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.is_last |=> req_stall)
      else $error("input open right after the last element");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("element count beyond buffer depth");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.is_last |=> !$rose(rsp_valid_ff))
      else $error("result raised without computing");

endmodule
